// ===== sv/itss_pkg.sv =====
// itss_pkg: shared types, constants and functions for the integer to
// seven-segment converter
// no dependencies
package itss_pkg;

  localparam int NumDigits = 4;
  localparam int DigitMax  = 9;
  localparam int MagWidth  = 14;
  localparam int CodeWidth = 32;
  localparam int NumWidth  = 15;

  localparam logic [7:0] SegMinus = 8'h02;
  localparam logic signed [NumWidth-1:0] MaxShown = 15'sd9999;
  localparam logic signed [NumWidth-1:0] MinShown = -15'sd999;

  typedef logic [1:0] pos_t;

  // word handed from one digit cell to the next
  typedef struct packed {
    logic [MagWidth-1:0]  rem;
    logic                 neg;
    logic                 err;
    logic                 started;
    logic [CodeWidth-1:0] code;
  } itss_word_t;

  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] f;
    case (d)
      4'd0:    f = 8'hfc;
      4'd1:    f = 8'h60;
      4'd2:    f = 8'hda;
      4'd3:    f = 8'hf2;
      4'd4:    f = 8'h66;
      4'd5:    f = 8'hb6;
      4'd6:    f = 8'hbe;
      4'd7:    f = 8'he0;
      4'd8:    f = 8'hfe;
      4'd9:    f = 8'hf6;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  function automatic logic [MagWidth-1:0] pow10(input pos_t pos);
    logic [MagWidth-1:0] p;
    case (pos)
      2'd3:    p = 14'd1000;
      2'd2:    p = 14'd100;
      2'd1:    p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/integer_to_seven_segment.sv =====
// Signed integer to four-digit seven-segment code. A word is taken every
// cycle; each result is registered in turn by the row of four digit cells
// (one per display position, thousands to units). A stall on the result
// side holds the whole row. Out-of-range numbers give a zero code with the
// error flag set.
// depends on itss_pkg and itss_digit_cell
module integer_to_seven_segment
  import itss_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [NumWidth-1:0]  in_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CodeWidth-1:0]        out_segment_code,
  output logic                        out_range_error
);

  logic                adv;
  logic                valid_c [NumDigits+1];
  itss_word_t          word_c  [NumDigits+1];
  logic                neg;
  logic                err;
  logic [NumWidth-1:0] mag;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign neg = in_number[NumWidth-1];
  assign err = (in_number > MaxShown) || (in_number < MinShown);
  assign mag = neg ? NumWidth'(-in_number) : NumWidth'(in_number);

  always_comb begin
    word_c[NumDigits]         = '0;
    word_c[NumDigits].rem     = err ? '0 : mag[MagWidth-1:0];
    word_c[NumDigits].neg     = neg;
    word_c[NumDigits].err     = err;
    valid_c[NumDigits]        = in_valid;
  end

  for (genvar i = NumDigits - 1; i >= 0; i--) begin : g_cell
    itss_digit_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .pos       (pos_t'(i)),
      .valid_in  (valid_c[i+1]),
      .word_in   (word_c[i+1]),
      .valid_out (valid_c[i]),
      .word_out  (word_c[i])
    );
  end

  assign out_valid        = valid_c[0];
  assign out_segment_code = word_c[0].code;
  assign out_range_error  = word_c[0].err;

endmodule

// ===== sv/itss_digit_cell.sv =====
// itss_digit_cell: one pipeline cell, extracts the decimal digit at its
// position and writes its segment byte and any minus sign into the word
// depends on itss_pkg
module itss_digit_cell
  import itss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  pos_t       pos,
  input  logic       valid_in,
  input  itss_word_t word_in,
  output logic       valid_out,
  output itss_word_t word_out
);

  logic                valid_r;
  itss_word_t          word_r;
  itss_word_t          word_nxt;
  logic [MagWidth-1:0] pow;
  logic [17:0]         step;
  logic [17:0]         sub;
  logic [3:0]          d;
  pos_t                pos_up;

  assign pow    = pow10(pos);
  assign pos_up = pos + 2'd1;

  // digit by parallel compare against the nine multiples
  always_comb begin
    d    = '0;
    sub  = '0;
    step = '0;
    for (int k = 1; k <= DigitMax; k++) begin
      step = 18'(k) * {4'b0000, pow};
      if ({4'b0000, word_in.rem} >= step) begin
        d   = 4'(k);
        sub = step;
      end
    end
  end

  always_comb begin
    word_nxt     = word_in;
    word_nxt.rem = word_in.rem - sub[MagWidth-1:0];
    if (!word_in.err) begin
      if (d != 4'd0) begin
        if (!word_in.started && word_in.neg && pos != 2'd3) begin
          word_nxt.code[{pos_up, 3'b000} +: 8] = SegMinus;
        end
        word_nxt.started = 1'b1;
        word_nxt.code[{pos, 3'b000} +: 8] = seg_font(d);
      end else if (word_in.started || pos == 2'd0) begin
        word_nxt.code[{pos, 3'b000} +: 8] = seg_font(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign valid_out = valid_r;
  assign word_out  = word_r;

endmodule

// ===== tb/integer_to_seven_segment_tb.sv =====
`timescale 1ns / 100ps
// integer_to_seven_segment_tb: drives signed numbers into the seven-segment
// converter and checks every code and error flag against a local predictor
// depends on itss_pkg and integer_to_seven_segment
module integer_to_seven_segment_tb;
  import itss_pkg::*;

  localparam int HoldCycles = 200;
  localparam logic [79:0] Glyphs = {8'hf6, 8'hfe, 8'he0, 8'hbe, 8'hb6,
                                    8'h66, 8'hf2, 8'hda, 8'h60, 8'hfc};

  typedef struct packed {
    logic [CodeWidth-1:0] code;
    logic                 err;
  } display_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [NumWidth-1:0] in_number = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [CodeWidth-1:0]       out_segment_code;
  logic                       out_range_error;

  display_t shown_q[$];
  int       mismatches = 0;
  bit       steady = 1'b0;
  bit       hold_req = 1'b0;
  bit       hold_active = 1'b0;

  integer_to_seven_segment dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segment_code (out_segment_code),
    .out_range_error  (out_range_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic display_t predict_display(input logic signed [NumWidth-1:0] num);
    display_t r;
    int       value;
    int       mag;
    int       scale;
    int       digit;
    int       pos;
    bit       neg;
    bit       lit;
    r.code = '0;
    r.err = 1'b0;
    value = int'(num);
    if (value > int'(MaxShown) || value < int'(MinShown)) begin
      r.err = 1'b1;
      return r;
    end
    neg = value < 0;
    mag = neg ? -value : value;
    scale = neg ? 100 : 1000;
    lit = 1'b0;
    for (pos = neg ? 2 : 3; pos >= 0; pos--) begin
      digit = (mag / scale) % 10;
      scale = scale / 10;
      if (digit != 0) begin
        // minus sits just left of the first nonzero digit
        if (!lit && neg) r.code[8*(pos+1) +: 8] = SegMinus;
        lit = 1'b1;
      end
      if (lit || pos == 0) r.code[8*pos +: 8] = Glyphs[8*digit +: 8];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    if (steady || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) shown_q.push_back(predict_display(in_number));
  end

  always @(posedge clk) begin
    display_t want;
    if (rst_n && out_valid && out_ready) begin
      if (shown_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual code %h err %b",
                 $time, out_segment_code, out_range_error);
      end else begin
        want = shown_q.pop_front();
        if (out_segment_code !== want.code) begin
          mismatches++;
          $display("%0t: segment_code mismatch, expected %h, actual %h",
                   $time, want.code, out_segment_code);
        end
        if (out_range_error !== want.err) begin
          mismatches++;
          $display("%0t: range_error mismatch, expected %b, actual %b",
                   $time, want.err, out_range_error);
        end
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_active = 1'b0;
        out_ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_number(input int v);
    int gap;
    in_valid <= 1'b1;
    in_number <= NumWidth'(v);
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_special_values();
    int picks[$];
    picks = '{0, 1, 9, 10, 90, 100, 1000, 1001, 1234, 5678, 9999, 10000, 16383,
              -1, -7, -9, -10, -90, -100, -105, -999, -1000, -16384, 909};
    foreach (picks[i]) send_number(picks[i]);
  endtask

  task automatic test_digit_counts();
    int n;
    int lo;
    int hi;
    int v;
    for (n = 1; n <= 4; n++) begin
      lo = (n == 1) ? 0 : 10 ** (n - 1);
      hi = 10 ** n - 1;
      repeat (10) begin
        v = $urandom_range(lo, hi);
        send_number(v);
        if (n < 4) send_number(-v);
      end
    end
  endtask

  task automatic test_back_pressure();
    int v;
    in_valid <= 1'b0;
    steady = 1'b1;
    hold_req = 1'b1;
    wait (hold_active);
    repeat (40) begin
      v = $urandom_range(0, 10998);
      send_number(v - 999);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_values();
    int i;
    int r;
    int v;
    for (i = 0; i < 560; i++) begin
      steady = (i >= 200 && i < 260);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        v = $urandom_range(0, 10998);
        v = v - 999;
      end else if (r < 80) begin
        case ($urandom_range(0, 4))
          0:       v = -999;
          1:       v = 9999;
          2:       v = 0;
          3:       v = -100;
          default: v = 1000;
        endcase
        v = v + $urandom_range(0, 4) - 2;
      end else begin
        v = $urandom_range(0, 32767);
      end
      send_number(v);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_special_values();
    test_digit_counts();
    test_back_pressure();
    test_random_values();
    in_valid <= 1'b0;
    while (shown_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("status: fail");
    $finish;
  end

endmodule
